### hw/rtl/mss_pkg.sv
`default_nettype none

package mss_pkg;

  localparam int VALUE_W         = 16;
  localparam int DIGIT_W         = 4;
  localparam int SEG_W           = 8;
  localparam int EN_W            = 4;
  localparam int LIT_W           = 2;
  localparam int DWELL_W         = 16;
  localparam int POINT_W         = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;
  localparam int DIGIT_COUNT_DEF = 4;
  localparam int MAX_PLACES      = 6;
  localparam int RECIP_W         = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_DIGIT = 1'd1;

  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd5;
  localparam logic [POINT_W-1:0] POINT_RESET = 2'd1;
  localparam logic [SEG_W-1:0]   POINT_SEG   = 8'h80;

  // floor(v / 10**k) = (v * RECIP_M[k]) >> RECIP_S[k] for every 16-bit v
  localparam logic [RECIP_W-1:0] RECIP_M [MAX_PLACES] = '{
    17'd1, 17'd104858, 17'd83887, 17'd67109, 17'd107375, 17'd85900
  };
  localparam int RECIP_S [MAX_PLACES] = '{0, 20, 23, 26, 30, 33};

  function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] f;
    case (d)
      4'd0: f = 8'h3F;
      4'd1: f = 8'h06;
      4'd2: f = 8'h5B;
      4'd3: f = 8'h4F;
      4'd4: f = 8'h66;
      4'd5: f = 8'h6D;
      4'd6: f = 8'h7D;
      4'd7: f = 8'h07;
      4'd8: f = 8'h7F;
      4'd9: f = 8'h6F;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mss_if.sv
`default_nettype none

interface mss_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [mss_pkg::VALUE_W-1:0]   shown_value;
  modport source (output valid, mode, shown_value, input ready);
  modport sink (input valid, mode, shown_value, output ready);
endinterface

interface mss_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mss_pkg::SEG_W-1:0]     segment_lines_n;
  logic [mss_pkg::EN_W-1:0]      digit_enable_n;
  logic [mss_pkg::LIT_W-1:0]     lit_digit;
  modport source (output valid, segment_lines_n, digit_enable_n, lit_digit, input ready);
  modport sink (input valid, segment_lines_n, digit_enable_n, lit_digit, output ready);
endinterface

interface mss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mss_pkg::CFG_IDX_W-1:0]  index;
  logic [mss_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/multiplexed_seven_segment_scanner.sv
// Four-digit multiplexed seven-segment scanner.
// req channel: mode 0 loads shown_value, split into decimal digits (the
// leftmost digit is taken mod 10); mode 1 is one scan tick. Every request
// gives exactly one rsp item: active-low segments (bit7 decimal point),
// active-low one-hot digit enable (bit0 leftmost digit) and the lit index.
// cfg channel: index 0 dwell_ticks (ticks per digit, 0 acts as 1),
// index 1 point_digit. Always ready; write only while idle.
// Pipeline: input register, then decimal split by reciprocal
// multiplication, digit extraction and state update in one pass into the
// output register. An accepted request moves from the input register into
// the output register; one request is taken per cycle when rsp is not stalled.
// While rsp stalls, the output and input registers hold; ready drops once
// the input register cannot move, so up to two requests wait in flight.
// Reset: digits clear to 0000, scan index and dwell count to zero,
// dwell_ticks to 5, point_digit to 1, all stages empty.
`default_nettype none

module multiplexed_seven_segment_scanner #(
  parameter int DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  mss_req_if.sink   req,
  mss_rsp_if.source rsp,
  mss_cfg_if.sink   cfg
);

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int VW    = mss_pkg::VALUE_W;

  logic                                s1_valid;
  logic                                s1_mode;
  logic [VW-1:0]                       s1_value;
  logic [DIGIT_COUNT:0][VW-1:0]        quot;

  logic [mss_pkg::DIGIT_W-1:0]         store [DIGIT_COUNT];
  logic [mss_pkg::DIGIT_W-1:0]         store_next [DIGIT_COUNT];
  logic [IDX_W-1:0]                    scan;
  logic [IDX_W-1:0]                    scan_next;
  logic [mss_pkg::DWELL_W-1:0]         dwell_count;
  logic [mss_pkg::DWELL_W-1:0]         dwell_count_next;
  logic [mss_pkg::DWELL_W-1:0]         dwell_ticks;
  logic [mss_pkg::POINT_W-1:0]         point_digit;

  logic                                out_valid;
  logic [mss_pkg::SEG_W-1:0]           seg_n;
  logic [mss_pkg::EN_W-1:0]            en_n;
  logic [mss_pkg::LIT_W-1:0]           lit;

  logic                                adv_out;
  logic                                adv1;
  logic                                take;

  logic [mss_pkg::DWELL_W-1:0]         cnt_inc;
  logic [mss_pkg::DWELL_W-1:0]         limit;
  logic [2:0]                          pos3;
  logic [2:0]                          pt3;
  logic [mss_pkg::DIGIT_W-1:0]         cur_digit;
  logic [mss_pkg::SEG_W-1:0]           seg;
  logic [mss_pkg::EN_W-1:0]            en;

  assign adv_out   = !out_valid || rsp.ready;
  assign adv1      = s1_valid && adv_out;
  assign take      = req.valid && req.ready;
  assign req.ready = !s1_valid || adv1;
  assign cfg.ready = 1'b1;

  assign rsp.valid           = out_valid;
  assign rsp.segment_lines_n = seg_n;
  assign rsp.digit_enable_n  = en_n;
  assign rsp.lit_digit       = lit;

  mss_split #(.DIGIT_COUNT(DIGIT_COUNT)) u_split (
    .value (s1_value),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv1) begin
      s1_valid <= 1'b0;
    end
    if (take) begin
      s1_mode  <= req.mode;
      s1_value <= req.shown_value;
    end
  end

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      store_next[i] = store[i];
    end
    scan_next        = scan;
    dwell_count_next = dwell_count;
    cnt_inc          = dwell_count + 16'd1;
    limit            = (dwell_ticks == '0) ? 16'd1 : dwell_ticks;
    if (!s1_mode) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        store_next[i] = mss_pkg::DIGIT_W'(quot[DIGIT_COUNT-1-i]
                        - ((quot[DIGIT_COUNT-i] << 3) + (quot[DIGIT_COUNT-i] << 1)));
      end
    end else if (cnt_inc >= limit || cnt_inc == '0) begin
      dwell_count_next = '0;
      scan_next = (scan == IDX_W'(DIGIT_COUNT - 1)) ? '0 : scan + 1'b1;
    end else begin
      dwell_count_next = cnt_inc;
    end
  end

  always_comb begin
    pos3      = 3'(scan_next);
    pt3       = {1'b0, point_digit};
    cur_digit = store_next[scan_next];
    seg       = mss_pkg::seg_font(cur_digit);
    if (pt3 == pos3 && pt3 < 3'(DIGIT_COUNT)) begin
      seg = seg | mss_pkg::POINT_SEG;
    end
    en = pos3[2] ? '0 : (4'b0001 << pos3[1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        store[i] <= '0;
      end
      scan        <= '0;
      dwell_count <= '0;
    end else if (adv1) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        store[i] <= store_next[i];
      end
      scan        <= scan_next;
      dwell_count <= dwell_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv1) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (adv1) begin
      seg_n <= ~seg;
      en_n  <= ~en;
      lit   <= pos3[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= mss_pkg::DWELL_RESET;
      point_digit <= mss_pkg::POINT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        mss_pkg::REG_DWELL_TICKS: dwell_ticks <= cfg.data[mss_pkg::DWELL_W-1:0];
        mss_pkg::REG_POINT_DIGIT: point_digit <= cfg.data[mss_pkg::POINT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mss_split.sv
`default_nettype none

module mss_split #(
  parameter int DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEF
) (
  input  wire logic [mss_pkg::VALUE_W-1:0]                value,
  output logic      [DIGIT_COUNT:0][mss_pkg::VALUE_W-1:0] quot
);

  localparam int PROD_W = mss_pkg::VALUE_W + mss_pkg::RECIP_W;

  for (genvar k = 0; k <= DIGIT_COUNT; k++) begin : g_place
    logic [PROD_W-1:0] prod;
    assign prod    = {{mss_pkg::RECIP_W{1'b0}}, value}
                   * {{mss_pkg::VALUE_W{1'b0}}, mss_pkg::RECIP_M[k]};
    assign quot[k] = mss_pkg::VALUE_W'(prod >> mss_pkg::RECIP_S[k]);
  end

endmodule

`default_nettype wire

### sim/multiplexed_seven_segment_scanner_tb.sv
`timescale 1ns / 1ps

module multiplexed_seven_segment_scanner_tb;

  localparam int DIGITS      = 4;
  localparam int STALL_LIMIT = 3000;

  localparam logic [mss_pkg::SEG_W-1:0] GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic                        mode;
    logic [mss_pkg::VALUE_W-1:0] value;
  } scan_req_t;

  typedef struct packed {
    logic [mss_pkg::SEG_W-1:0] seg_n;
    logic [mss_pkg::EN_W-1:0]  en_n;
    logic [mss_pkg::LIT_W-1:0] lit;
  } panel_lines_t;

  logic clk;
  logic rst;

  mss_req_if req_if ();
  mss_rsp_if rsp_if ();
  mss_cfg_if cfg_if ();

  multiplexed_seven_segment_scanner dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  scan_req_t    pending_reqs [$];
  panel_lines_t expected_lines [$];
  scan_req_t    next_req;
  panel_lines_t got_lines;
  panel_lines_t want_lines;

  logic [mss_pkg::DIGIT_W-1:0] shown_digits [DIGITS];
  logic [mss_pkg::LIT_W-1:0]   scan_pos;
  logic [mss_pkg::DWELL_W-1:0] dwell_count;
  logic [mss_pkg::DWELL_W-1:0] dwell_ticks;
  logic [mss_pkg::POINT_W-1:0] point_digit;

  int send_idle_pct;
  int recv_stall_pct;
  int issued_count;
  int accepted_count;
  int mismatch_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic panel_lines_t scan_predict(input scan_req_t item);
    panel_lines_t                lines;
    logic [mss_pkg::DWELL_W-1:0] limit;
    logic [mss_pkg::SEG_W-1:0]   glyph;
    int                          v;
    v = int'(item.value);
    if (!item.mode) begin
      shown_digits[0] = mss_pkg::DIGIT_W'((v / 1000) % 10);
      shown_digits[1] = mss_pkg::DIGIT_W'((v / 100) % 10);
      shown_digits[2] = mss_pkg::DIGIT_W'((v / 10) % 10);
      shown_digits[3] = mss_pkg::DIGIT_W'(v % 10);
    end else begin
      limit = (dwell_ticks == '0) ? mss_pkg::DWELL_W'(1) : dwell_ticks;
      dwell_count = dwell_count + 1'b1;
      if (dwell_count >= limit || dwell_count == '0) begin
        dwell_count = '0;
        scan_pos = (scan_pos == mss_pkg::LIT_W'(DIGITS - 1)) ? '0 : scan_pos + 1'b1;
      end
    end
    glyph = GLYPH[shown_digits[scan_pos]];
    if (point_digit == scan_pos) glyph = glyph | mss_pkg::POINT_SEG;
    lines.seg_n = ~glyph;
    lines.en_n  = ~(mss_pkg::EN_W'(1) << scan_pos);
    lines.lit   = scan_pos;
    return lines;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h, want 0x%0h (request %0d)", what, got, want,
             accepted_count);
    mismatch_count++;
  endtask

  task automatic queue_req(input logic mode, input logic [mss_pkg::VALUE_W-1:0] value);
    pending_reqs.push_back('{mode: mode, value: value});
    issued_count++;
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_req(1'b1, mss_pkg::VALUE_W'($urandom_range(65535)));
  endtask

  task automatic wait_idle();
    while (accepted_count != issued_count || expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [mss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mss_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == mss_pkg::REG_DWELL_TICKS) dwell_ticks = value;
    else if (idx == mss_pkg::REG_POINT_DIGIT) point_digit = value[mss_pkg::POINT_W-1:0];
  endtask

  function automatic logic [mss_pkg::VALUE_W-1:0] pick_value();
    logic [mss_pkg::VALUE_W-1:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      2: v = mss_pkg::VALUE_W'($urandom_range(9999));
      3: v = mss_pkg::VALUE_W'($urandom_range(19999, 9990));
      default: v = mss_pkg::VALUE_W'($urandom_range(65535));
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        req_if.valid       <= 1'b1;
        req_if.mode        <= next_req.mode;
        req_if.shown_value <= next_req.value;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        expected_lines.push_back(scan_predict('{mode: req_if.mode,
                                                value: req_if.shown_value}));
        accepted_count++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got_lines = '{seg_n: rsp_if.segment_lines_n, en_n: rsp_if.digit_enable_n,
                      lit: rsp_if.lit_digit};
        if (expected_lines.size() == 0) begin
          report_mismatch("result with no request pending", int'(got_lines), 0);
        end else begin
          want_lines = expected_lines.pop_front();
          if (got_lines.seg_n !== want_lines.seg_n)
            report_mismatch("segment_lines_n", got_lines.seg_n, want_lines.seg_n);
          if (got_lines.en_n !== want_lines.en_n)
            report_mismatch("digit_enable_n", got_lines.en_n, want_lines.en_n);
          if (got_lines.lit !== want_lines.lit)
            report_mismatch("lit_digit", got_lines.lit, want_lines.lit);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph;
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.mode        = 1'b0;
    req_if.shown_value = '0;
    rsp_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    issued_count       = 0;
    accepted_count     = 0;
    mismatch_count     = 0;
    for (int i = 0; i < DIGITS; i++) shown_digits[i] = '0;
    scan_pos    = '0;
    dwell_count = '0;
    dwell_ticks = mss_pkg::DWELL_RESET;
    point_digit = mss_pkg::POINT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset state shows 0000, then extremes with default dwell and point
    queue_ticks(1);
    queue_req(1'b0, 16'd65535);
    queue_req(1'b0, 16'd0);
    queue_ticks(4);
    queue_req(1'b0, 16'd9999);
    wait_idle();

    // zero dwell acts as one: scan every tick
    cfg_write(mss_pkg::REG_DWELL_TICKS, 16'd0);
    cfg_write(mss_pkg::REG_POINT_DIGIT, 16'd0);
    queue_req(1'b0, 16'd10000);
    queue_ticks(4);
    queue_req(1'b0, 16'd1234);
    queue_ticks(1);
    queue_req(1'b0, 16'd8765);
    wait_idle();

    cfg_write(mss_pkg::REG_DWELL_TICKS, 16'd65535);
    cfg_write(mss_pkg::REG_POINT_DIGIT, 16'd3);
    queue_ticks(3);
    queue_req(1'b0, 16'd43210);
    wait_idle();

    // lower dwell below the running count: next tick advances
    cfg_write(mss_pkg::REG_DWELL_TICKS, 16'd2);
    cfg_write(mss_pkg::REG_POINT_DIGIT, 16'd2);
    queue_ticks(3);
    queue_req(1'b0, 16'd5);
    wait_idle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      cfg_write(mss_pkg::REG_DWELL_TICKS, mss_pkg::CFG_DATA_W'($urandom_range(6)));
      cfg_write(mss_pkg::REG_POINT_DIGIT, mss_pkg::CFG_DATA_W'($urandom_range(3)));
      repeat (260) begin
        if ($urandom_range(99) < 70) queue_ticks(1);
        else queue_req(1'b0, pick_value());
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mss_pkg.sv
hw/rtl/mss_if.sv
hw/rtl/mss_split.sv
hw/rtl/multiplexed_seven_segment_scanner.sv
sim/multiplexed_seven_segment_scanner_tb.sv
